FILE: hw/rtl/dcec_pkg.sv
// shared constants, types and status codes of the drift cell efficiency cut
// no dependencies; the front, queue, table, back and top files import this package
package dcec_pkg;

	// table geometry
	localparam int MODULE_COUNT = 4;
	localparam int STEP_COUNT   = 18;
	localparam int STEP_LAST    = 17;
	localparam int TABLE_DEPTH  = MODULE_COUNT * STEP_COUNT;
	localparam int ADDR_W       = $clog2(TABLE_DEPTH);

	// angle folding in 1/64 degree
	localparam int STEP_W = 5;
	localparam int F_W    = 13;
	localparam int REM_W  = 9;
	localparam logic [14:0] Q6_90  = 15'd5760;
	localparam logic [14:0] Q6_180 = 15'd11520;
	localparam logic [14:0] Q6_270 = 15'd17280;
	localparam logic [14:0] Q6_360 = 15'd23040;
	localparam int Q6_STEP   = 320;
	localparam int HALF_STEP = Q6_STEP / 2;

	// floor(x/5) for x below 1024 as (x*205)>>10
	localparam int DEG_RECIP5 = 205;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// result status codes
	typedef enum logic [1:0] {
		ST_REJECT     = 2'd0,
		ST_ACCEPT     = 2'd1,
		ST_WRITE_DONE = 2'd2,
		ST_WRITE_BAD  = 2'd3
	} dcec_status_t;

	// classified command handed from front to back
	typedef struct packed {
		logic                is_write;
		logic                write_ok;
		logic                mod_ok;
		logic [ADDR_W-1:0]   addr1;
		logic [ADDR_W-1:0]   addr2;
		logic [REM_W-1:0]    rem;
		logic [31:0]         wdata;
		logic signed [15:0]  distance;
		logic signed [15:0]  length;
	} dcec_cmd_t;

endpackage

FILE: hw/rtl/dcec_in_if.sv
// input channel of the efficiency cut: valid/ready plus the item fields
// no dependencies
interface dcec_in_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic [1:0]         module_req;
	logic [4:0]         angle_index;
	logic signed [15:0] entry_max_r;
	logic signed [15:0] entry_slope;
	logic signed [15:0] distance;
	logic [14:0]        impact_angle;
	logic signed [15:0] length;

	modport source (
		output valid, action, module_req, angle_index, entry_max_r, entry_slope,
		       distance, impact_angle, length,
		input  ready
	);
	modport sink (
		input  valid, action, module_req, angle_index, entry_max_r, entry_slope,
		       distance, impact_angle, length,
		output ready
	);
endinterface

FILE: hw/rtl/dcec_out_if.sv
// result channel of the efficiency cut: valid/ready plus status and cut radius
// no dependencies
interface dcec_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic signed [31:0] cut_radius;

	modport source (output valid, status, cut_radius, input ready);
	modport sink (input valid, status, cut_radius, output ready);
endinterface

FILE: hw/rtl/dcec_front.sv
// front end: accepts items, folds the angle, picks table addresses and remainder
// depends on dcec_pkg and dcec_in_if
module dcec_front import dcec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dcec_in_if.sink    items,
	input  logic       q_full,
	output logic       push,
	output dcec_cmd_t  push_cmd
);

	logic              s1_valid_q;
	dcec_cmd_t         cmd_s1;
	dcec_cmd_t         cmd_c;
	logic [14:0]       a;
	logic [F_W-1:0]    f;
	logic [6:0]        deg;
	logic [14:0]       step_prod;
	logic [STEP_W-1:0] step_raw;
	logic [STEP_W-1:0] step;
	logic [STEP_W-1:0] step2;
	logic [F_W-1:0]    rem_full;
	logic [ADDR_W-1:0] base;
	logic              mod_ok;
	logic              idx_ok;

	assign push        = s1_valid_q && !q_full;
	assign push_cmd    = cmd_s1;
	assign items.ready = !s1_valid_q || !q_full;

	// fold angle into one quadrant and split into step and remainder
	always_comb begin
		a = items.impact_angle;
		if (a <= Q6_90) begin
			f = F_W'(Q6_90 - a);
		end else if (a <= Q6_180) begin
			f = F_W'(a - Q6_90);
		end else if (a <= Q6_270) begin
			f = F_W'(a - Q6_180);
		end else if (a < Q6_360) begin
			f = F_W'(a - Q6_270);
		end else begin
			f = '0;
		end
		deg       = f[F_W-1:6];
		step_prod = 15'(deg) * 15'(DEG_RECIP5);
		step_raw  = step_prod[14:10];
		step      = (step_raw > STEP_W'(STEP_LAST)) ? STEP_W'(STEP_LAST) : step_raw;
		rem_full  = f - F_W'(step) * F_W'(Q6_STEP);
		step2     = (step == STEP_W'(STEP_LAST)) ? step : step + 1'b1;
	end

	// bank base, range checks and command assembly
	always_comb begin
		base   = ADDR_W'(int'(items.module_req) * STEP_COUNT);
		mod_ok = int'(items.module_req) < MODULE_COUNT;
		idx_ok = items.angle_index < STEP_W'(STEP_COUNT);

		cmd_c.is_write = items.action;
		cmd_c.write_ok = idx_ok && mod_ok;
		cmd_c.mod_ok   = mod_ok;
		cmd_c.addr1    = base + ADDR_W'(items.action ? items.angle_index : step);
		cmd_c.addr2    = base + ADDR_W'(step2);
		cmd_c.rem      = rem_full[REM_W-1:0];
		cmd_c.wdata    = {items.entry_max_r, items.entry_slope};
		cmd_c.distance = items.distance;
		cmd_c.length   = items.length;
	end

	// stage register, holds while the queue is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (items.valid && items.ready) begin
			s1_valid_q <= 1'b1;
		end else if (push) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			cmd_s1 <= cmd_c;
		end
	end

endmodule

FILE: hw/rtl/dcec_queue.sv
// short command queue that decouples the front end from the back end
// depends on dcec_pkg
module dcec_queue import dcec_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  dcec_cmd_t push_cmd,
	output logic      full,
	input  logic      pop,
	output logic      head_valid,
	output dcec_cmd_t head
);

	dcec_cmd_t         entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = entries_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// fill count stays within depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	// front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	// an empty queue is never popped
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop)
		else $error("pop from empty queue");

endmodule

FILE: hw/rtl/dcec_table.sv
// cut table: one write port, two registered read ports, per-entry valid bits
// depends on dcec_pkg
module dcec_table import dcec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        pop,
	input  dcec_cmd_t   cmd,
	output logic [31:0] rd1,
	output logic [31:0] rd2
);

	logic [31:0]            mem_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [31:0]            data1_s2;
	logic [31:0]            data2_s2;
	logic                   vld1_s2;
	logic                   vld2_s2;
	logic                   we;

	assign we  = pop && cmd.is_write && cmd.write_ok;
	assign rd1 = vld1_s2 ? data1_s2 : '0;
	assign rd2 = vld2_s2 ? data2_s2 : '0;

	// valid bits, cleared by reset so unwritten entries read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[cmd.addr1] <= 1'b1;
		end
	end

	// storage write and registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[cmd.addr1] <= cmd.wdata;
		end
		if (adv) begin
			data1_s2 <= mem_q[cmd.addr1];
			data2_s2 <= mem_q[cmd.addr2];
			vld1_s2  <= valid_q[cmd.addr1];
			vld2_s2  <= valid_q[cmd.addr2];
		end
	end

	// writes land inside the table
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> int'(cmd.addr1) < TABLE_DEPTH)
		else $error("table write beyond depth");

endmodule

FILE: hw/rtl/dcec_back.sv
// back end: radius products, interpolation with rounding, saturation, result register
// depends on dcec_pkg and dcec_out_if; reads table data from dcec_table
module dcec_back import dcec_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        head_valid,
	input  dcec_cmd_t   head,
	input  logic [31:0] rd1,
	input  logic [31:0] rd2,
	output logic        adv,
	output logic        pop,
	dcec_out_if.source  results
);

	localparam int R_W = 33;
	localparam int D_W = 34;
	localparam int N_W = 44;
	localparam int Y_W = 40;
	localparam int Q_W = 36;
	localparam int S_W = 37;
	localparam int RECIP5 = 3277;
	localparam logic [Y_W-1:0] Y_BIAS = Y_W'(5) << 34;
	localparam logic signed [Y_W:0] Q_BIAS = (Y_W+1)'(1) <<< 34;
	localparam logic signed [S_W-1:0] SAT_HI = {{(S_W-31){1'b0}}, {31{1'b1}}};
	localparam logic signed [S_W-1:0] SAT_LO = {{(S_W-31){1'b1}}, {31{1'b0}}};

	typedef struct packed {
		logic               is_write;
		logic               write_ok;
		logic               mod_ok;
		logic [REM_W-1:0]   rem;
		logic signed [15:0] distance;
	} dcec_ctl_t;

	typedef struct packed {
		logic [7:0] q;
		logic [2:0] r;
	} div5_t;

	// one radix-256 digit of a division by five
	function automatic div5_t div5_digit(input logic [2:0] r, input logic [7:0] d);
		logic [10:0] t;
		logic [24:0] prod;
		div5_t       res;
		t     = {r, d};
		prod  = 25'(t) * 25'(RECIP5);
		res.q = prod[21:14];
		res.r = 3'(t - 11'(res.q) * 11'd5);
		return res;
	endfunction

	logic v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic out_valid_q;
	dcec_ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_s7;
	logic signed [15:0] length_s2;
	logic signed [15:0] maxr1_s3, maxr2_s3;
	logic signed [31:0] p1_s3, p2_s3;
	logic signed [R_W-1:0] r1_s4, r1_s5, r1_s6, r1_s7;
	logic signed [D_W-1:0] diff_s4;
	logic signed [N_W-1:0] num_s5;
	logic [15:0] qh_s6;
	logic [2:0]  dr_s6;
	logic [23:0] ylo_s6;
	logic signed [Q_W-1:0] quo_s7;
	dcec_status_t status_q;
	logic signed [31:0] cut_q;

	logic [31:0] e1, e2;
	logic signed [R_W-1:0] r1_c, r2_c;
	logic signed [N_W-1:0] num_c;
	logic [Y_W-1:0] y_c;
	div5_t d4, d3, d2, d1, d0;
	logic [Y_W-1:0] qfull_c;
	logic signed [Y_W:0] qs_c;
	logic signed [S_W-1:0] sum_c;
	logic signed [31:0] cut_c;
	logic signed [31:0] dist_c;

	assign adv = !out_valid_q || results.ready;
	assign pop = adv && head_valid;

	assign results.valid      = out_valid_q;
	assign results.status     = status_q;
	assign results.cut_radius = cut_q;

	// stage valid chain, every stage moves together with the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			v_s7        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s2        <= pop;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			v_s7        <= v_s6;
			out_valid_q <= v_s7;
		end
	end

	// datapath combinational pieces
	always_comb begin
		e1 = ctl_s2.mod_ok ? rd1 : '0;
		e2 = ctl_s2.mod_ok ? rd2 : '0;

		r1_c = (R_W'(maxr1_s3) <<< 8) + R_W'(p1_s3);
		r2_c = (R_W'(maxr2_s3) <<< 8) + R_W'(p2_s3);

		num_c = N_W'(diff_s4) * N_W'($signed({1'b0, ctl_s4.rem})) + N_W'(HALF_STEP);

		// biased so the floor division below works on a positive value
		y_c = Y_W'(num_s5 >>> 6) + Y_BIAS;
		d4  = div5_digit(3'd0, y_c[39:32]);
		d3  = div5_digit(d4.r, y_c[31:24]);

		d2 = div5_digit(dr_s6, ylo_s6[23:16]);
		d1 = div5_digit(d2.r, ylo_s6[15:8]);
		d0 = div5_digit(d1.r, ylo_s6[7:0]);
		qfull_c = {qh_s6, d2.q, d1.q, d0.q};
		qs_c    = $signed({1'b0, qfull_c}) - Q_BIAS;

		sum_c = S_W'(r1_s7) + S_W'(quo_s7);
		if (sum_c > SAT_HI) begin
			cut_c = SAT_HI[31:0];
		end else if (sum_c < SAT_LO) begin
			cut_c = SAT_LO[31:0];
		end else begin
			cut_c = sum_c[31:0];
		end
		dist_c = $signed({ctl_s7.distance, 8'h00});
	end

	// pipeline registers
	always_ff @(posedge clk) begin
		if (adv) begin
			// table read stage, data comes registered from the table
			ctl_s2.is_write <= head.is_write;
			ctl_s2.write_ok <= head.write_ok;
			ctl_s2.mod_ok   <= head.mod_ok;
			ctl_s2.rem      <= head.rem;
			ctl_s2.distance <= head.distance;
			length_s2       <= head.length;

			// slope products
			ctl_s3   <= ctl_s2;
			maxr1_s3 <= $signed(e1[31:16]);
			maxr2_s3 <= $signed(e2[31:16]);
			p1_s3    <= length_s2 * $signed(e1[15:0]);
			p2_s3    <= length_s2 * $signed(e2[15:0]);

			// radii and their difference
			ctl_s4  <= ctl_s3;
			r1_s4   <= r1_c;
			diff_s4 <= D_W'(r2_c) - D_W'(r1_c);

			// weighted difference with rounding offset
			ctl_s5 <= ctl_s4;
			r1_s5  <= r1_s4;
			num_s5 <= num_c;

			// upper quotient digits
			ctl_s6 <= ctl_s5;
			r1_s6  <= r1_s5;
			qh_s6  <= {d4.q, d3.q};
			dr_s6  <= d3.r;
			ylo_s6 <= y_c[23:0];

			// lower quotient digits, bias removed
			ctl_s7 <= ctl_s6;
			r1_s7  <= r1_s6;
			quo_s7 <= qs_c[Q_W-1:0];

			// result register
			if (ctl_s7.is_write) begin
				status_q <= ctl_s7.write_ok ? ST_WRITE_DONE : ST_WRITE_BAD;
				cut_q    <= '0;
			end else begin
				status_q <= (dist_c > cut_c) ? ST_REJECT : ST_ACCEPT;
				cut_q    <= cut_c;
			end
		end
	end

	// write transactions always report a zero cut
	a_write_zero_cut: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status == ST_WRITE_DONE || results.status == ST_WRITE_BAD)
		|-> results.cut_radius == '0)
		else $error("write result with nonzero cut");

	// a popped command reaches the table read stage on the next edge
	a_pop_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s2)
		else $error("popped command lost before read stage");

endmodule

FILE: hw/rtl/drift_cell_efficiency_cut.sv
// top level of the drift cell efficiency cut
// depends on dcec_pkg, dcec_in_if, dcec_out_if, dcec_front, dcec_queue, dcec_table, dcec_back
//
// Takes one transaction per clock while the result channel is ready: writes load a
// (max radius, slope) entry of an 18-step table per module, evaluates fold the
// impact angle, read two neighboring steps, interpolate the cut radius with
// round-to-nearest and report accept or reject. A result passes through the front
// stage, the four-entry queue and the seven back stages (table read, slope products,
// radii, weighted difference, a two-stage divide by five, saturation and compare).
// The table is cleared at reset through per-entry valid bits, so no clearing pass
// is needed. An evaluate right after a write to the same entry sees the new value.
module drift_cell_efficiency_cut import dcec_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	dcec_in_if.sink    items,
	dcec_out_if.source results
);

	logic        q_full;
	logic        push;
	dcec_cmd_t   push_cmd;
	logic        head_valid;
	dcec_cmd_t   head;
	logic        adv;
	logic        pop;
	logic [31:0] rd1;
	logic [31:0] rd2;

	// classify and queue incoming transactions
	dcec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	dcec_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// table storage and arithmetic back end
	dcec_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.pop    (pop),
		.cmd    (head),
		.rd1    (rd1),
		.rd2    (rd2)
	);

	dcec_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.rd1        (rd1),
		.rd2        (rd2),
		.adv        (adv),
		.pop        (pop),
		.results    (results)
	);

endmodule
